[rtl/ecgshr_pkg.sv]
// shared types and constants for the ecg slope heart rate core
`timescale 1ns / 1ps

package ecgshr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 20;
  localparam int SLOPE_W  = 18;
  localparam int INTV_W   = 16;
  localparam int TOUT_W   = 16;
  localparam int SRATE_W  = 14;
  localparam int CFG_W    = 18;
  localparam int INDEX_W  = 3;

  typedef logic [INDEX_W-1:0] reg_index_t;

  localparam reg_index_t REG_SLOPE_LOW     = 3'd0;
  localparam reg_index_t REG_SLOPE_HIGH    = 3'd1;
  localparam reg_index_t REG_MIN_INTERVAL  = 3'd2;
  localparam reg_index_t REG_TIMEOUT_LIMIT = 3'd3;
  localparam reg_index_t REG_SAMPLE_RATE   = 3'd4;

  localparam logic [SLOPE_W-1:0] SLOPE_LOW_RST     = 18'd100;
  localparam logic [SLOPE_W-1:0] SLOPE_HIGH_RST    = 18'd1000;
  localparam logic [INTV_W-1:0]  MIN_INTERVAL_RST  = 16'd60;
  localparam logic [TOUT_W-1:0]  TIMEOUT_LIMIT_RST = 16'd1000;
  localparam logic [SRATE_W-1:0] SAMPLE_RATE_RST   = 14'd500;

  // one quotient bit per divider step
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage

[rtl/ecg_slope_heart_rate_core.sv]
// ecg slope heart rate core: window, slope, peak tracking and rate division
//
//   channel   | signals                                  | role
//   ----------+------------------------------------------+-----------------------
//   sample    | sample_valid, sample_ready, sample[15:0] | ecg samples in
//   rate      | rate_valid, rate_ready, bpm[19:0]        | one rate per sample out
//   config    | cfg_write, cfg_index, cfg_data           | register writes
//
// a fill sample goes straight to output; a slope sample passes the slope states and
// evaluation, and the divider when a new rate is divided out (one quotient bit per
// cycle through the shared adder, which also forms the slope and peak distances).
// sample_ready is high only while the sequencer is idle; a finished item waits in
// the output register, and the core holds its result if rate is still stalled.
// rst is synchronous and restores the config and state registers to their defaults.
`timescale 1ns / 1ps

module ecg_slope_heart_rate_core #(
  parameter int WINDOW_LEN  = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [ecgshr_pkg::SAMPLE_W-1:0] sample,
  output logic                                rate_valid,
  input  logic                                rate_ready,
  output logic [ecgshr_pkg::RATE_W-1:0]       bpm,
  input  logic                                cfg_write,
  input  logic [ecgshr_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [ecgshr_pkg::CFG_W-1:0]        cfg_data
);

  localparam int SW        = ecgshr_pkg::SAMPLE_W;
  localparam int RW        = ecgshr_pkg::RATE_W;
  localparam int STORE_LEN = WINDOW_LEN - 1;
  localparam int FILL_W    = $clog2(WINDOW_LEN + 1);
  localparam int AW        = (COUNT_WIDTH + 2 > RW) ? COUNT_WIDTH + 2 : RW;
  localparam int TW        = (COUNT_WIDTH > ecgshr_pkg::TOUT_W) ? COUNT_WIDTH
                                                                : ecgshr_pkg::TOUT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SLP1 = 4'd1;
  localparam logic [3:0] S_SLP2 = 4'd2;
  localparam logic [3:0] S_SLP3 = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_PEAK = 4'd5;
  localparam logic [3:0] S_INTV = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_PUT  = 4'd8;

  logic [3:0] state;

  logic [ecgshr_pkg::SLOPE_W-1:0] slope_low;
  logic [ecgshr_pkg::SLOPE_W-1:0] slope_high;
  logic [ecgshr_pkg::INTV_W-1:0]  min_interval;
  logic [ecgshr_pkg::TOUT_W-1:0]  timeout_limit;
  logic [ecgshr_pkg::SRATE_W-1:0] sample_rate_hz;

  logic [SW-1:0]          win [STORE_LEN];
  logic [SW-1:0]          xs;
  logic [FILL_W-1:0]      fill_count;
  logic [COUNT_WIDTH-1:0] sample_counter;
  logic [COUNT_WIDTH-1:0] first_position;
  logic [COUNT_WIDTH-1:0] second_position;
  logic [COUNT_WIDTH-1:0] timeout_count;
  logic                   first_seen;
  logic                   second_seen;
  logic [RW-1:0]          last_rate;
  logic                   zero_res;

  logic signed [AW-1:0]   acc;
  logic [COUNT_WIDTH-1:0] divisor;
  logic [COUNT_WIDTH-1:0] rem;
  logic [RW-1:0]          dvd;
  logic [ecgshr_pkg::DIV_CNT_W-1:0] div_cnt;

  // shared adder
  logic signed [AW-1:0] alu_a;
  logic signed [AW-1:0] alu_b;
  logic                 alu_sub;
  logic signed [AW-1:0] alu_res;

  logic [COUNT_WIDTH-1:0] sc_inc;
  logic [COUNT_WIDTH-1:0] tc_inc;
  logic                   below_low;
  logic                   above_high;
  logic                   above_low;
  logic [RW-1:0]          rate60;
  logic                   accept;

  assign accept       = sample_valid && sample_ready;
  assign sample_ready = (state == S_IDLE);

  assign sc_inc = (sample_counter == {COUNT_WIDTH{1'b1}}) ? sample_counter
                                                          : sample_counter + 1'b1;
  assign tc_inc = (timeout_count == {COUNT_WIDTH{1'b1}}) ? timeout_count
                                                         : timeout_count + 1'b1;

  assign below_low  = acc < $signed({{(AW-ecgshr_pkg::SLOPE_W){1'b0}}, slope_low});
  assign above_high = acc > $signed({{(AW-ecgshr_pkg::SLOPE_W){1'b0}}, slope_high});
  assign above_low  = acc > $signed({{(AW-ecgshr_pkg::SLOPE_W){1'b0}}, slope_low});

  // 60 * rate as 64x - 4x
  assign rate60 = {sample_rate_hz, 6'b0} - {4'b0, sample_rate_hz, 2'b0};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_SLP1: begin
        alu_a   = {{(AW-SW-1){xs[SW-1]}}, xs, 1'b0};
        alu_b   = {{(AW-SW-1){win[0][SW-1]}}, win[0], 1'b0};
        alu_sub = 1'b1;
      end
      S_SLP2: begin
        alu_a = acc;
        alu_b = {{(AW-SW){win[STORE_LEN-1][SW-1]}}, win[STORE_LEN-1]};
      end
      S_SLP3: begin
        alu_a   = acc;
        alu_b   = {{(AW-SW){win[1][SW-1]}}, win[1]};
        alu_sub = 1'b1;
      end
      S_PEAK: begin
        alu_a   = {{(AW-COUNT_WIDTH){1'b0}}, sample_counter};
        alu_b   = {{(AW-COUNT_WIDTH){1'b0}}, first_position};
        alu_sub = 1'b1;
      end
      S_INTV: begin
        alu_a   = {{(AW-COUNT_WIDTH){1'b0}}, second_position};
        alu_b   = {{(AW-COUNT_WIDTH){1'b0}}, first_position};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {{(AW-COUNT_WIDTH-1){1'b0}}, rem, dvd[RW-1]};
        alu_b   = {{(AW-COUNT_WIDTH){1'b0}}, divisor};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
    alu_res = alu_sub ? alu_a - alu_b : alu_a + alu_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_low      <= ecgshr_pkg::SLOPE_LOW_RST;
      slope_high     <= ecgshr_pkg::SLOPE_HIGH_RST;
      min_interval   <= ecgshr_pkg::MIN_INTERVAL_RST;
      timeout_limit  <= ecgshr_pkg::TIMEOUT_LIMIT_RST;
      sample_rate_hz <= ecgshr_pkg::SAMPLE_RATE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ecgshr_pkg::REG_SLOPE_LOW:     slope_low      <= cfg_data;
        ecgshr_pkg::REG_SLOPE_HIGH:    slope_high     <= cfg_data;
        ecgshr_pkg::REG_MIN_INTERVAL:  min_interval   <= cfg_data[ecgshr_pkg::INTV_W-1:0];
        ecgshr_pkg::REG_TIMEOUT_LIMIT: timeout_limit  <= cfg_data[ecgshr_pkg::TOUT_W-1:0];
        ecgshr_pkg::REG_SAMPLE_RATE:   sample_rate_hz <= cfg_data[ecgshr_pkg::SRATE_W-1:0];
        default: ;
      endcase
    end
  end

  // sample window shift line
  always_ff @(posedge clk) begin
    if ((accept && fill_count < FILL_W'(WINDOW_LEN)) || state == S_SLP3) begin
      for (int i = 0; i < STORE_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[STORE_LEN-1] <= (state == S_SLP3) ? xs : sample;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      xs <= sample;
    end
    if (state == S_SLP1 || state == S_SLP2 || state == S_SLP3) begin
      acc <= alu_res;
    end
    if (state == S_INTV) begin
      divisor <= alu_res[COUNT_WIDTH-1:0];
      rem     <= '0;
      dvd     <= rate60;
    end else if (state == S_DIV) begin
      if (!alu_res[AW-1]) begin
        rem <= alu_res[COUNT_WIDTH-1:0];
      end else begin
        rem <= alu_a[COUNT_WIDTH-1:0];
      end
      dvd <= {dvd[RW-2:0], ~alu_res[AW-1]};
    end
    if (state == S_PUT && (!rate_valid || rate_ready)) begin
      bpm <= zero_res ? '0 : last_rate;
    end
  end

  // sequencer and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      fill_count      <= '0;
      sample_counter  <= '0;
      first_position  <= '0;
      second_position <= '0;
      timeout_count   <= '0;
      first_seen      <= 1'b0;
      second_seen     <= 1'b0;
      last_rate       <= '0;
      zero_res        <= 1'b0;
      div_cnt         <= '0;
      rate_valid      <= 1'b0;
    end else begin
      if (rate_valid && rate_ready && state != S_PUT) begin
        rate_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (fill_count < FILL_W'(WINDOW_LEN)) begin
              fill_count <= fill_count + 1'b1;
              zero_res   <= 1'b1;
              state      <= S_PUT;
            end else begin
              zero_res <= 1'b0;
              state    <= S_SLP1;
            end
          end
        end
        S_SLP1: state <= S_SLP2;
        S_SLP2: state <= S_SLP3;
        S_SLP3: state <= S_EVAL;
        S_EVAL: begin
          if (below_low || above_high) begin
            sample_counter <= sc_inc;
            timeout_count  <= tc_inc;
            if (TW'(tc_inc) > TW'(timeout_limit)) begin
              last_rate <= '0;
            end
            state <= S_PUT;
          end else begin
            timeout_count <= '0;
            if (!first_seen || !second_seen) begin
              if (above_low && first_seen) begin
                state <= S_PEAK;
              end else begin
                if (above_low) begin
                  first_seen     <= 1'b1;
                  first_position <= sample_counter;
                end
                sample_counter <= sc_inc;
                state          <= S_PUT;
              end
            end else begin
              state <= S_INTV;
            end
          end
        end
        S_PEAK: begin
          // second peak only counts once far enough from the first
          second_position <= sample_counter;
          second_seen     <= TW'(alu_res[COUNT_WIDTH-1:0]) >= TW'(min_interval);
          sample_counter  <= sc_inc;
          state           <= S_PUT;
        end
        S_INTV: begin
          first_seen     <= 1'b0;
          second_seen    <= 1'b0;
          sample_counter <= '0;
          div_cnt        <= ecgshr_pkg::DIV_CNT_W'(ecgshr_pkg::DIV_STEPS);
          if (alu_res[COUNT_WIDTH-1:0] == '0) begin
            last_rate <= '0;
            state     <= S_PUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == ecgshr_pkg::DIV_CNT_W'(1)) begin
            last_rate <= {dvd[RW-2:0], ~alu_res[AW-1]};
            state     <= S_PUT;
          end
        end
        S_PUT: begin
          if (!rate_valid || rate_ready) begin
            rate_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/ecg_slope_heart_rate_core_test.sv]
// testbench for the ecg slope heart rate core: directed and random samples against a predictor
`timescale 1ns / 1ps

module ecg_slope_heart_rate_core_test;

  localparam int WINDOW_LEN = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_LEN = 300;
  localparam int TAIL_CYCLES = 40;
  localparam logic [ecgshr_pkg::RATE_W-1:0] RATE_LIMIT = '1;
  localparam logic [ecgshr_pkg::TOUT_W-1:0] COUNT_TOP = '1;
  // indexes past the last register, the core must ignore writes to them
  localparam ecgshr_pkg::reg_index_t SPARE_INDEX_LO = 3'd5;
  localparam ecgshr_pkg::reg_index_t SPARE_INDEX_HI = 3'd7;

  typedef logic signed [ecgshr_pkg::SAMPLE_W-1:0] sample_t;

  logic clk = 1'b0;
  logic rst;
  logic sample_valid;
  logic sample_ready;
  sample_t sample;
  logic rate_valid;
  logic rate_ready;
  logic [ecgshr_pkg::RATE_W-1:0] bpm;
  logic cfg_write;
  logic [ecgshr_pkg::INDEX_W-1:0] cfg_index;
  logic [ecgshr_pkg::CFG_W-1:0] cfg_data;

  ecg_slope_heart_rate_core #(
    .WINDOW_LEN (WINDOW_LEN),
    .COUNT_WIDTH(16)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .rate_valid  (rate_valid),
    .rate_ready  (rate_ready),
    .bpm         (bpm),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [ecgshr_pkg::SLOPE_W-1:0] band_low;
  logic [ecgshr_pkg::SLOPE_W-1:0] band_high;
  logic [ecgshr_pkg::INTV_W-1:0] peak_gap;
  logic [ecgshr_pkg::TOUT_W-1:0] run_limit;
  logic [ecgshr_pkg::SRATE_W-1:0] rate_hz;

  // predictor copy of the state
  sample_t hist [0:WINDOW_LEN-2];
  int fill_n;
  logic [ecgshr_pkg::TOUT_W-1:0] pos_count;
  logic [ecgshr_pkg::TOUT_W-1:0] run_len;
  logic first_pk;
  logic second_pk;
  logic [ecgshr_pkg::TOUT_W-1:0] first_at;
  logic [ecgshr_pkg::TOUT_W-1:0] second_at;
  logic [ecgshr_pkg::RATE_W-1:0] held_rate;

  logic [ecgshr_pkg::RATE_W-1:0] pending_rates [$];
  logic [ecgshr_pkg::RATE_W-1:0] oldest_rate;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  function automatic logic [ecgshr_pkg::TOUT_W-1:0] bump(
      input logic [ecgshr_pkg::TOUT_W-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic void push_history(input sample_t x);
    for (int i = 0; i < WINDOW_LEN - 2; i++) hist[i] = hist[i + 1];
    hist[WINDOW_LEN-2] = x;
  endfunction

  function automatic void reset_predictor();
    band_low = ecgshr_pkg::SLOPE_LOW_RST;
    band_high = ecgshr_pkg::SLOPE_HIGH_RST;
    peak_gap = ecgshr_pkg::MIN_INTERVAL_RST;
    run_limit = ecgshr_pkg::TIMEOUT_LIMIT_RST;
    rate_hz = ecgshr_pkg::SAMPLE_RATE_RST;
    for (int i = 0; i < WINDOW_LEN - 1; i++) hist[i] = '0;
    fill_n = 0;
    pos_count = '0;
    run_len = '0;
    first_pk = 1'b0;
    second_pk = 1'b0;
    first_at = '0;
    second_at = '0;
    held_rate = '0;
  endfunction

  function automatic logic [ecgshr_pkg::RATE_W-1:0] expected_bpm(input sample_t x);
    longint slope;
    longint lo;
    longint hi;
    logic [ecgshr_pkg::INTV_W-1:0] span;
    longint unsigned quotient;
    lo = band_low;
    hi = band_high;
    if (fill_n < WINDOW_LEN) begin
      push_history(x);
      fill_n++;
      return '0;
    end
    slope = -2 * longint'(hist[0]) - longint'(hist[1]) + longint'(hist[WINDOW_LEN-2])
            + 2 * longint'(x);
    push_history(x);
    if (slope < lo || slope > hi) begin
      pos_count = bump(pos_count);
      run_len = bump(run_len);
      if (run_len > run_limit) held_rate = '0;
      return held_rate;
    end
    run_len = '0;
    if (!(first_pk && second_pk)) begin
      // slope exactly on the low edge is in band but is no peak
      if (slope > lo) begin
        if (!first_pk) begin
          first_pk = 1'b1;
          first_at = pos_count;
        end else begin
          second_at = pos_count;
          second_pk = ((second_at - first_at) >= peak_gap);
        end
      end
      pos_count = bump(pos_count);
    end else begin
      span = second_at - first_at;
      if (span == 0) begin
        held_rate = '0;
      end else begin
        quotient = (64'd60 * rate_hz) / span;
        held_rate = (quotient > RATE_LIMIT) ? RATE_LIMIT
                                            : quotient[ecgshr_pkg::RATE_W-1:0];
      end
      first_pk = 1'b0;
      second_pk = 1'b0;
      pos_count = '0;
    end
    return held_rate;
  endfunction

  // sample that brings the slope as close to the target as the window allows
  function automatic sample_t sample_for_slope(input longint target);
    longint need;
    longint half;
    sample_t x;
    need = target + 2 * longint'(hist[0]) + longint'(hist[1]) - longint'(hist[WINDOW_LEN-2]);
    half = need / 2;
    if (half > 32767) half = 32767;
    if (half < -32768) half = -32768;
    x = half[ecgshr_pkg::SAMPLE_W-1:0];
    return x;
  endfunction

  function automatic longint pick_slope();
    int pick;
    int spread;
    longint lo;
    longint hi;
    lo = band_low;
    hi = band_high;
    pick = $urandom_range(99);
    if (lo > hi || pick < 5) begin
      spread = $urandom_range(393204);
      return longint'(spread) - 196602;
    end
    if (pick < 15) return lo;
    if (pick < 22) return hi;
    if (pick < 35) begin
      spread = $urandom_range(500);
      return lo - 1 - spread;
    end
    if (pick < 45) begin
      spread = $urandom_range(20000);
      return hi + 1 + spread;
    end
    spread = $urandom_range(int'(hi - lo));
    return lo + spread;
  endfunction

  task automatic send_sample(input sample_t x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= x;
    do @(posedge clk); while (!sample_ready);
    pending_rates.push_back(expected_bpm(x));
  endtask

  task automatic send_slope(input longint target);
    send_sample(sample_for_slope(target));
  endtask

  task automatic end_phase();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input ecgshr_pkg::reg_index_t idx,
                           input logic [ecgshr_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      ecgshr_pkg::REG_SLOPE_LOW:     band_low = data[ecgshr_pkg::SLOPE_W-1:0];
      ecgshr_pkg::REG_SLOPE_HIGH:    band_high = data[ecgshr_pkg::SLOPE_W-1:0];
      ecgshr_pkg::REG_MIN_INTERVAL:  peak_gap = data[ecgshr_pkg::INTV_W-1:0];
      ecgshr_pkg::REG_TIMEOUT_LIMIT: run_limit = data[ecgshr_pkg::TOUT_W-1:0];
      ecgshr_pkg::REG_SAMPLE_RATE:   rate_hz = data[ecgshr_pkg::SRATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [ecgshr_pkg::CFG_W-1:0] lo,
                                input logic [ecgshr_pkg::CFG_W-1:0] hi,
                                input logic [ecgshr_pkg::CFG_W-1:0] gap,
                                input logic [ecgshr_pkg::CFG_W-1:0] lim,
                                input logic [ecgshr_pkg::CFG_W-1:0] hz);
    write_reg(ecgshr_pkg::REG_SLOPE_LOW, lo);
    write_reg(ecgshr_pkg::REG_SLOPE_HIGH, hi);
    write_reg(ecgshr_pkg::REG_MIN_INTERVAL, gap);
    write_reg(ecgshr_pkg::REG_TIMEOUT_LIMIT, lim);
    write_reg(ecgshr_pkg::REG_SAMPLE_RATE, hz);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) send_sample(sample_t'($urandom));
      else send_slope(pick_slope());
    end
  endtask

  // window fill at the register defaults, then slopes around both band edges
  task automatic test_fill_and_band_edges();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_slope(100);
    send_slope(1000);
    send_slope(99);
    send_slope(1001);
    send_slope(101);
    end_phase();
  endtask

  // two peaks, a new rate, then a timeout back to zero
  task automatic test_peak_to_rate();
    apply_settings(50, 2000, 1, 2, 10000);
    send_slope(300);
    send_slope(50);
    send_slope(300);
    send_slope(60);
    send_slope(5000);
    send_slope(5000);
    send_slope(5000);
    send_slope(-5000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    end_phase();
  endtask

  task automatic test_inverted_band();
    apply_settings(196608, 0, 65535, 0, 1);
    write_reg(SPARE_INDEX_LO, '1);
    write_reg(SPARE_INDEX_HI, 18'h15555);
    @(negedge clk);
    cfg_write <= 1'b0;
    send_random_items(20);
    end_phase();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic extremes);
    if (extremes) begin
      apply_settings(0, 196608, 1, 65535, 1);
    end else begin
      apply_settings($urandom_range(3000), 0, $urandom_range(1, 30), $urandom_range(40),
                     $urandom_range(1, 10000));
      write_reg(ecgshr_pkg::REG_SLOPE_HIGH, band_low + $urandom_range(30000));
      @(negedge clk);
      cfg_write <= 1'b0;
    end
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    send_random_items(115);
    end_phase();
  endtask

  // rate side holds off while samples keep coming, so the core backs up
  task automatic test_output_backpressure();
    apply_settings(1000, 196000, 65535, 65535, 10000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_off_cycles = HOLD_OFF_LEN;
    send_random_items(15);
    end_phase();
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      rate_ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      rate_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rate_valid && rate_ready) begin
      if (pending_rates.size() == 0) begin
        $error("bpm: nothing expected, got %0d", bpm);
        mismatch_count++;
      end else begin
        oldest_rate = pending_rates.pop_front();
        if (bpm !== oldest_rate) begin
          $error("bpm: expected %0d, got %0d", oldest_rate, bpm);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ecg_slope_heart_rate_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    rate_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_fill_and_band_edges();
    test_peak_to_rate();
    test_inverted_band();
    test_random_traffic(0, 0, 1'b1);
    test_random_traffic(46, 0, 1'b0);
    test_random_traffic(0, 46, 1'b0);
    test_random_traffic(30, 30, 1'b0);
    test_output_backpressure();

    while (pending_rates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ecg_slope_heart_rate_core_test: done, clean");
    end else begin
      $display("ecg_slope_heart_rate_core_test: done, errors");
    end
    $finish;
  end

endmodule

[ecg_slope_heart_rate_core.f]
rtl/ecgshr_pkg.sv
rtl/ecg_slope_heart_rate_core.sv
tb/sv/ecg_slope_heart_rate_core_test.sv
